>>> rtl/core/line_follower_pid_steering_macros.svh
// Assertion helpers used by the RTL.
`ifndef LINE_FOLLOWER_PID_STEERING_MACROS_SVH
`define LINE_FOLLOWER_PID_STEERING_MACROS_SVH
`define LFPS_ASSERT_IMPL(lbl, clk_i, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LFPS_ASSERT_NEXT(lbl, clk_i, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> rtl/core/lfps_pkg.sv
package lfps_pkg;
	localparam int CalSamplesDef = 500;
	localparam int MaxSpeedDef = 255;
	localparam int DivW = 32;
	localparam logic [2:0] RegProp = 3'd0;
	localparam logic [2:0] RegInteg = 3'd1;
	localparam logic [2:0] RegDeriv = 3'd2;
	localparam logic [2:0] RegSpeed = 3'd3;
	localparam logic [2:0] RegGround = 3'd4;
	localparam logic [2:0] RegLost = 3'd5;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

>>> rtl/core/lfps_div.sv
module lfps_div
	import lfps_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DivW-1:0] dividend,
	input  logic [DivW-1:0] divisor,
	output div_ctl_t        ctl,
	output logic [DivW-1:0] quotient
);
	localparam int CntW = $clog2(DivW + 1);

	logic [DivW-1:0] q_q;
	logic [DivW:0]   r_q;
	logic [DivW-1:0] d_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DivW:0]   r_sh;
	logic [DivW:0]   r_sub;

	assign r_sh  = {r_q[DivW-1:0], q_q[DivW-1]};
	assign r_sub = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DivW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!r_sub[DivW]) begin
				r_q <= r_sub;
				q_q <= {q_q[DivW-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[DivW-2:0], 1'b0};
			end
		end
	end

	assign quotient  = q_q;
	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;
endmodule

>>> rtl/core/lfps_mul.sv
module lfps_mul
	import lfps_pkg::*;
(
	input  logic               clk,
	input  logic               start,
	input  logic signed [31:0] a,
	input  logic        [15:0] b,
	output logic signed [31:0] prod
);
	logic signed [31:0] acc_q;
	logic signed [31:0] a_q;
	logic        [15:0] b_q;

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign prod = acc_q;
endmodule

>>> rtl/core/line_follower_pid_steering.sv
// An accepted input beat passes through calibration, a 32-step serial position division
// (its result is not awaited when the line is lost), the PID update, three shift-add
// multiplies done one after another and a 32-step serial speed division before
// m_axis_tvalid rises; the next beat is taken only once the previous result is stored.
// A finished result waits in the output register while the next beat is taken in.
// Reset (arst_n low, asynchronous) restores registers, minima to 2000, calibration count,
// last position 5000, and clears the PID state.
`include "line_follower_pid_steering_macros.svh"
module line_follower_pid_steering
	import lfps_pkg::*;
#(
	parameter int CAL_SAMPLES = CalSamplesDef,
	parameter int MAX_SPEED = MaxSpeedDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// sample_left[11:0], sample_mid[23:12], sample_right[35:24], battery_mv[48:36]
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// duty_a[9:0], duty_b[19:10], line_pos_um[33:20]
	output logic [39:0] m_axis_tdata,
	// line_seen
	output logic        m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [13:0] cfg_data
);
	localparam logic [3:0] StIdle = 4'd0, StCal = 4'd1, StDiv1 = 4'd2, StWait1 = 4'd3,
		StPid = 4'd4, StMulP = 4'd5, StMulI = 4'd6, StMulD = 4'd7, StDiv2 = 4'd8,
		StWait2 = 4'd9, StOut = 4'd10, StMulW = 4'd11;
	localparam logic [9:0] CalInit = 10'(CAL_SAMPLES);
	localparam logic [7:0] SpeedCap = 8'(MAX_SPEED / 2);

	logic [3:0] st_q;
	logic [4:0] mcnt_q;
	logic [11:0] gp_q, gi_q, gd_q, spd_set_q, gnd_q;
	logic [13:0] lost_q;
	logic [11:0] min_q [3];
	logic [9:0] calrem_q;
	logic signed [13:0] last_q;
	logic signed [10:0] integ_q;
	logic signed [9:0] prev_q;
	logic signed [10:0] davg_q;
	logic [11:0] raw_q [3];
	logic [12:0] bat_q;
	logic [11:0] cal_q [3];
	logic [13:0] sum_q;
	logic signed [13:0] pos_q;
	logic seen_q;
	logic signed [9:0] err_q;
	logic signed [31:0] ctl_q;
	logic [7:0] speed_q;
	logic signed [9:0] steer_q;
	logic ov_q;
	logic [39:0] od_q;
	logic ou_q;
	logic [DivW-1:0] dvd, dvs, quo;
	div_ctl_t dctl;
	logic dstart, mstart;
	logic signed [31:0] ma, mprod;
	logic [15:0] mb;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (st_q == StIdle);
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = od_q;
	assign m_axis_tuser = ou_q;

	lfps_div u_div (.clk, .arst_n, .start(dstart), .dividend(dvd), .divisor(dvs),
		.ctl(dctl), .quotient(quo));
	lfps_mul u_mul (.clk, .start(mstart), .a(ma), .b(mb), .prod(mprod));

	logic [16:0] wsum;
	logic signed [10:0] errw;
	logic signed [11:0] isum;
	logic signed [11:0] dsum;
	logic signed [10:0] dnext;
	logic signed [10:0] inext;
	logic signed [31:0] ctlsh;
	logic [13:0] msum;
	logic [11:0] mnew [3];
	logic [26:0] mscaled [3];
	logic calen;

	always_comb begin
		wsum = 17'(cal_q[0]) + 17'({cal_q[1], 1'b0}) + 17'(cal_q[2]) + 17'({cal_q[2], 1'b0});
		msum = 14'(cal_q[0]) + 14'(cal_q[1]) + 14'(cal_q[2]);
		calen = (calrem_q != '0) && raw_q[0] < gnd_q && raw_q[1] < gnd_q && raw_q[2] < gnd_q;
		for (int k = 0; k < 3; k++) begin
			// (8*min + raw) / 9 as a multiply by 3641 / 2^15, exact for minima below 2048.
			mscaled[k] = 27'(15'({min_q[k], 3'b0}) + 15'(raw_q[k])) * 27'd3641;
			mnew[k] = min_q[k];
			if (calen && raw_q[k] < min_q[k]) mnew[k] = 12'(mscaled[k] >> 15);
		end
		errw = 11'(pos_q >>> 4);
		isum = 12'(integ_q) + 12'(errw);
		if (isum > 12'sd900) inext = 11'sd900;
		else if (isum < -12'sd900) inext = -11'sd900;
		else inext = isum[10:0];
		dsum = 12'(davg_q) + 12'(prev_q) - 12'(errw);
		dnext = 11'((dsum + ((dsum < 0) ? 12'sd1 : 12'sd0)) >>> 1);
		ctlsh = ctl_q >>> 13;
		dstart = 1'b0;
		mstart = 1'b0;
		dvd = '0;
		dvs = 32'd1;
		ma = '0;
		mb = '0;
		unique case (st_q)
			StDiv1: begin
				dstart = 1'b1;
				dvd = 32'(wsum) * 32'd7500;
				dvs = 32'(msum);
			end
			StMulP: begin
				mstart = 1'b1;
				ma = 32'(err_q);
				mb = 16'(gp_q >> 1);
			end
			StMulI: begin
				mstart = 1'b1;
				ma = 32'(integ_q);
				mb = 16'(gi_q >> 2);
			end
			StMulD: begin
				mstart = 1'b1;
				ma = 32'(davg_q);
				mb = 16'(gd_q >> 2);
			end
			StDiv2: begin
				dstart = 1'b1;
				dvd = 32'(speed_q) * 32'd3900;
				dvs = 32'(bat_q);
			end
			default: ;
		endcase
	end

	logic [3:0] mret_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle;
			ov_q <= 1'b0;
			gp_q <= 12'd2048; gi_q <= '0; gd_q <= 12'd2048;
			spd_set_q <= '0; gnd_q <= 12'd3400; lost_q <= 14'd1400;
			for (int k = 0; k < 3; k++) min_q[k] <= 12'd2000;
			calrem_q <= CalInit;
			last_q <= 14'sd5000;
			integ_q <= '0; prev_q <= '0; davg_q <= '0;
			mcnt_q <= '0; mret_q <= StIdle;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					RegProp: gp_q <= cfg_data[11:0];
					RegInteg: gi_q <= cfg_data[11:0];
					RegDeriv: gd_q <= cfg_data[11:0];
					RegSpeed: spd_set_q <= cfg_data[11:0];
					RegGround: gnd_q <= cfg_data[11:0];
					RegLost: lost_q <= cfg_data;
					default: ;
				endcase
			end
			if (ov_q && m_axis_tready) ov_q <= 1'b0;
			unique case (st_q) inside
				StIdle: if (s_axis_tvalid && s_axis_tready) begin
					raw_q[0] <= s_axis_tdata[11:0];
					raw_q[1] <= s_axis_tdata[23:12];
					raw_q[2] <= s_axis_tdata[35:24];
					bat_q <= (s_axis_tdata[48:36] < 13'd2000) ? 13'd2000 :
						(s_axis_tdata[48:36] > 13'd5000) ? 13'd5000 : s_axis_tdata[48:36];
					speed_q <= ((spd_set_q >> 5) > 12'(SpeedCap)) ? SpeedCap :
						8'(spd_set_q >> 5);
					st_q <= StCal;
				end
				StCal: begin
					for (int k = 0; k < 3; k++) begin
						min_q[k] <= mnew[k];
						cal_q[k] <= (raw_q[k] > mnew[k]) ? raw_q[k] - mnew[k] : '0;
					end
					if (calen) calrem_q <= calrem_q - 1'b1;
					st_q <= StDiv1;
				end
				StDiv1: begin
					sum_q <= msum;
					st_q <= StWait1;
				end
				StWait1: begin
					if (sum_q == '0 || sum_q < lost_q) begin
						seen_q <= 1'b0;
						pos_q <= (last_q > 0) ? 14'sd3750 : -14'sd3750;
						st_q <= StPid;
					end else if (dctl.done) begin
						seen_q <= 1'b1;
						pos_q <= 14'(quo) - 14'sd15000;
						last_q <= 14'(quo) - 14'sd15000;
						st_q <= StPid;
					end
				end
				StPid: begin
					err_q <= errw[9:0];
					integ_q <= seen_q ? 11'sd0 : inext;
					davg_q <= dnext;
					prev_q <= errw[9:0];
					ctl_q <= '0;
					st_q <= StMulP;
				end
				StMulP, StMulI, StMulD: begin
					mcnt_q <= 5'd17;
					mret_q <= (st_q == StMulP) ? StMulI : (st_q == StMulI) ? StMulD : StDiv2;
					st_q <= StMulW;
				end
				StMulW: begin
					mcnt_q <= mcnt_q - 1'b1;
					if (mcnt_q == 5'd1) begin
						ctl_q <= ctl_q + mprod;
						st_q <= mret_q;
					end
				end
				StDiv2: begin
					steer_q <= (ctlsh > $signed(32'(speed_q))) ? 10'(speed_q) :
						(ctlsh < -$signed(32'(speed_q))) ? -10'(speed_q) : 10'(ctlsh);
					st_q <= StWait2;
				end
				StWait2: if (dctl.done) begin
					st_q <= StOut;
				end
				StOut: if (!ov_q) begin
					od_q[9:0] <= 10'(quo) - steer_q;
					od_q[19:10] <= 10'(quo) + steer_q;
					od_q[33:20] <= pos_q;
					od_q[39:34] <= '0;
					ou_q <= seen_q;
					ov_q <= 1'b1;
					st_q <= StIdle;
				end
				default: st_q <= StIdle;
			endcase
		end
	end

	`LFPS_ASSERT_IMPL(a_no_take_busy, clk, arst_n, st_q != StIdle, !s_axis_tready, "ready while busy")
	`LFPS_ASSERT_IMPL(a_div_excl, clk, arst_n, dctl.done, !dctl.start, "divider overlap")
	`LFPS_ASSERT_NEXT(a_out_hold, clk, arst_n, ov_q && !m_axis_tready, ov_q && $stable(od_q), "out lost")
endmodule

>>> test/tb.sv
module tb;
	import lfps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [9:0]  duty_a;
		logic [9:0]  duty_b;
		logic        seen;
		logic [13:0] pos;
	} steer_out_t;

	typedef struct packed {
		bit          typed;
		steer_out_t  res;
		logic [11:0] left;
		logic [11:0] mid;
		logic [11:0] right;
		logic [12:0] bat;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [13:0] cfg_data;

	line_follower_pid_steering DUT (.*);

	int prop_g, integ_g, deriv_g, speed_set, ground_th, lost_th;
	int min_s[3];
	int cal_left, last_pos, integ_sum, prev_err, deriv_avg;

	steer_out_t duty_q[$];
	int errors;
	int burst_left;
	bit hold_req, hold_done;
	bit gaps_on;
	stim_row_t dir_rows[14];

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int floor_shr(int v, int k);
		return v >>> k;
	endfunction

	function automatic steer_out_t steer_predict(logic [55:0] d);
		int raw[3];
		int cal[3];
		int bat, sum, weighted, speed, pos, err, ctl, steer, spd;
		bit seen;
		steer_out_t o;
		raw[0] = d[11:0];
		raw[1] = d[23:12];
		raw[2] = d[35:24];
		bat = d[48:36];
		if (bat < 2000) bat = 2000;
		if (bat > 5000) bat = 5000;
		speed = speed_set >> 5;
		if (speed > 127) speed = 127;
		if (cal_left != 0 && raw[0] < ground_th && raw[1] < ground_th && raw[2] < ground_th) begin
			for (int k = 0; k < 3; k++)
				if (raw[k] < min_s[k]) min_s[k] = (8 * min_s[k] + raw[k]) / 9;
			cal_left = (cal_left - 1) & 10'h3ff;
		end
		for (int k = 0; k < 3; k++)
			cal[k] = raw[k] > min_s[k] ? raw[k] - min_s[k] : 0;
		sum = cal[0] + cal[1] + cal[2];
		if (sum == 0 || sum < lost_th) begin
			seen = 1'b0;
			pos = last_pos > 0 ? 3750 : -3750;
		end else begin
			weighted = 7500 * (cal[0] + 2 * cal[1] + 3 * cal[2]);
			pos = weighted / sum - 15000;
			seen = 1'b1;
			last_pos = pos;
		end
		err = floor_shr(pos, 4);
		integ_sum += err;
		if (integ_sum > 900) integ_sum = 900;
		if (integ_sum < -900) integ_sum = -900;
		if (seen) integ_sum = 0;
		deriv_avg = (deriv_avg + (prev_err - err)) / 2;
		prev_err = err;
		ctl = (prop_g >> 1) * err + (integ_g >> 2) * integ_sum + (deriv_g >> 2) * deriv_avg;
		steer = floor_shr(ctl, 13);
		if (steer > speed) steer = speed;
		if (steer < -speed) steer = -speed;
		spd = speed * 3900 / bat;
		o.duty_a = 10'(spd - steer);
		o.duty_b = 10'(spd + steer);
		o.seen = seen;
		o.pos = 14'(pos);
		return o;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		steer_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (duty_q.size() == 0) begin
				report("unexpected beat", 1, 0);
			end else begin
				want = duty_q.pop_front();
				if (m_axis_tdata[9:0] !== want.duty_a)
					report("duty_a", $signed(m_axis_tdata[9:0]), $signed(want.duty_a));
				if (m_axis_tdata[19:10] !== want.duty_b)
					report("duty_b", $signed(m_axis_tdata[19:10]), $signed(want.duty_b));
				if (m_axis_tdata[33:20] !== want.pos)
					report("line_pos_um", $signed(m_axis_tdata[33:20]), $signed(want.pos));
				if (m_axis_tuser !== want.seen)
					report("line_seen", m_axis_tuser, want.seen);
			end
		end
	end

	initial begin
		int phase_cnt, mode;
		m_axis_tready = 1'b0;
		phase_cnt = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (1500) @(negedge clk);
				hold_done = 1'b1;
			end
			if (phase_cnt == 0) begin
				mode = $urandom_range(0, 2);
				phase_cnt = $urandom_range(8, 80);
			end
			phase_cnt--;
			case (mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic cfg_write(logic [2:0] idx, int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 14'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			RegProp: prop_g = val & 12'hfff;
			RegInteg: integ_g = val & 12'hfff;
			RegDeriv: deriv_g = val & 12'hfff;
			RegSpeed: speed_set = val & 12'hfff;
			RegGround: ground_th = val & 12'hfff;
			RegLost: lost_th = val & 14'h3fff;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic cfg_all(int p, int i, int d, int s, int g, int l);
		cfg_write(RegProp, p);
		cfg_write(RegInteg, i);
		cfg_write(RegDeriv, d);
		cfg_write(RegSpeed, s);
		cfg_write(RegGround, g);
		cfg_write(RegLost, l);
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_beat(logic [55:0] d, bit typed, steer_out_t res);
		steer_out_t pred;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = gaps_on ? $urandom_range(1, 150) : 0;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pred = steer_predict(d);
		duty_q.push_back(typed ? res : pred);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (duty_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [55:0] pack_in(int l, int m, int r, int b);
		return {7'd0, 13'(b), 12'(r), 12'(m), 12'(l)};
	endfunction

	function automatic logic [55:0] rand_item();
		int s[3];
		int k, b;
		b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(2000, 5000);
		if ($urandom_range(0, 4) == 0) begin
			for (int j = 0; j < 3; j++) s[j] = $urandom_range(0, 4095);
		end else begin
			k = $urandom_range(0, 2);
			for (int j = 0; j < 3; j++) s[j] = $urandom_range(0, 1800);
			s[k] = $urandom_range(1500, 4095);
			if ($urandom_range(0, 2) == 0) s[(k + 1) % 3] = $urandom_range(800, 3300);
		end
		return pack_in(s[0], s[1], s[2], b);
	endfunction

	initial begin
		logic [55:0] d;
		int n;
		errors = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = RegProp;
		cfg_data = '0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		gaps_on = 1'b1;
		burst_left = 0;
		prop_g = 2048; integ_g = 0; deriv_g = 2048; speed_set = 0;
		ground_th = 3400; lost_th = 1400;
		for (int k = 0; k < 3; k++) min_s[k] = 2000;
		cal_left = CalSamplesDef; last_pos = 5000; integ_sum = 0;
		prev_err = 0; deriv_avg = 0;

		dir_rows = '{
			'{1'b1, '{10'd0, 10'd0, 1'b0, 14'd3750}, 12'd0, 12'd0, 12'd0, 13'd0},
			'{1'b0, '0, 12'd4095, 12'd4095, 12'd4095, 13'd8191},
			'{1'b0, '0, 12'd4095, 12'd0, 12'd0, 13'd1999},
			'{1'b0, '0, 12'd0, 12'd4095, 12'd0, 13'd2000},
			'{1'b0, '0, 12'd0, 12'd0, 12'd4095, 13'd5000},
			'{1'b0, '0, 12'd3000, 12'd0, 12'd0, 13'd5001},
			'{1'b0, '0, 12'd0, 12'd0, 12'd0, 13'd3900},
			'{1'b0, '0, 12'd2100, 12'd2100, 12'd2100, 13'd2500},
			'{1'b0, '0, 12'd0, 12'd3399, 12'd3300, 13'd4000},
			'{1'b0, '0, 12'd0, 12'd0, 12'd3390, 13'd3000},
			'{1'b0, '0, 12'd2500, 12'd0, 12'd0, 13'd2000},
			'{1'b0, '0, 12'd1500, 12'd1500, 12'd1500, 13'd6000},
			'{1'b0, '0, 12'd0, 12'd0, 12'd0, 13'd4096},
			'{1'b0, '0, 12'd2730, 12'd1365, 12'd2730, 13'd3000}
		};

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_beat(pack_in(dir_rows[0].left, dir_rows[0].mid, dir_rows[0].right,
			dir_rows[0].bat), 1'b1, dir_rows[0].res);
		drain();
		cfg_all(4095, 4095, 4095, 4095, 3400, 1400);
		for (int i = 1; i < 14; i++)
			send_beat(pack_in(dir_rows[i].left, dir_rows[i].mid, dir_rows[i].right,
				dir_rows[i].bat), dir_rows[i].typed, dir_rows[i].res);
		drain();
		cfg_all(0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 6; i++) send_beat(rand_item(), 1'b0, '0);
		drain();
		cfg_all(4095, 4095, 4095, 4095, 4095, 12285);
		for (int i = 0; i < 6; i++) send_beat(rand_item(), 1'b0, '0);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			cfg_all($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(1024, 4095),
				($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095) : 4095,
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 2000));
			gaps_on = (ph % 3 != 1);
			if (ph == 4) hold_req = 1'b1;
			n = 55;
			for (int i = 0; i < n; i++) begin
				d = rand_item();
				send_beat(d, 1'b0, '0);
			end
			drain();
		end

		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#30ms;
		$display("tb: failure");
		$finish;
	end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/lfps_pkg.sv
rtl/core/lfps_div.sv
rtl/core/lfps_mul.sv
rtl/core/line_follower_pid_steering.sv
test/tb.sv
